// ----- design/csl_pkg.sv -----
// Shared types and constants for the Chebyshev-series layer profile block.
// Holds the command and result transfer structs, op codes and fixed widths.
// No dependencies.
package csl_pkg;

    localparam int MAX_COEFS_DEF  = 16;
    localparam int MAX_LAYERS_DEF = 64;

    localparam int COEF_INDEX_W  = 4;
    localparam int COEF_W        = 32;
    localparam int LAYER_COUNT_W = 7;
    localparam int COEF_COUNT_W  = 5;
    localparam int LAYER_IDX_W   = 6;
    localparam int THICK_W       = 32;
    localparam int Q30_W         = 32;
    localparam int PROD_W        = 64;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    localparam logic [Q30_W-1:0] ONE_Q30 = 32'h4000_0000;

    typedef struct packed {
        logic                            op;
        logic [COEF_INDEX_W-1:0]         coef_index;
        logic signed [COEF_W-1:0]        coef_value;
        logic [LAYER_COUNT_W-1:0]        layer_count;
        logic [COEF_COUNT_W-1:0]         coef_count;
    } t_cmd;

    typedef struct packed {
        logic [LAYER_IDX_W-1:0] layer_index;
        logic [THICK_W-1:0]     thickness;
        logic                   last;
    } t_result;

endpackage

// ----- design/chebyshev_series_layer_profile.sv -----
// Chebyshev-series layer profile: sequencer, shared multiplier and accumulator.
// Depends on csl_pkg, csl_coef_ram and csl_div.
// Write transfer: completes at its accept edge, busy stays low.
// Compute transfer (L layers, P coefs): a division runs first when L >= 2, then each layer
// sums T terms, T = terms of the layer's parity below P; one shared 32x32 multiplier
// takes two passes per term and the store gives one coefficient read per term.
// Results come one per layer as a one-cycle o_strobe; the receiver cannot stall.
// Reset: sequencer idle, coefficient store reads as all zeros.
module chebyshev_series_layer_profile
    import csl_pkg::*;
#(
    parameter int MAX_COEFS = MAX_COEFS_DEF,
    parameter int MAX_LAYERS = MAX_LAYERS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_cmd,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int AW    = $clog2(MAX_COEFS);
    localparam int PW    = $clog2(MAX_COEFS + 1);
    localparam int JW    = $clog2(MAX_COEFS + 2);
    localparam int LCW   = $clog2(MAX_LAYERS + 1);
    localparam int LW    = $clog2(MAX_LAYERS);
    localparam int SUM_W = 34 + $clog2(MAX_COEFS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_LAYER = 3'd2;
    localparam logic [2:0] S_MUL_C = 3'd3;
    localparam logic [2:0] S_MUL_X = 3'd4;
    localparam logic [2:0] S_STEP  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]              r_state, n_state;
    logic [LCW-1:0]          r_lcnt, n_lcnt;
    logic [PW-1:0]           r_pcnt, n_pcnt;
    logic [LW-1:0]           r_layer, n_layer;
    logic [Q30_W-1:0]        r_xq, n_xq;
    logic [Q30_W-1:0]        r_qa, n_qa;
    logic [LCW-1:0]          r_ra, n_ra;
    logic [LCW-1:0]          r_racc, n_racc;
    logic [JW-1:0]           r_j, n_j;
    logic signed [Q30_W-1:0] r_x, n_x;
    logic signed [Q30_W-1:0] r_tprev, n_tprev;
    logic signed [Q30_W-1:0] r_tcur, n_tcur;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic                    r_strobe, n_strobe;
    t_result                 r_result, n_result;

    logic                    w_accept;
    logic [LCW-1:0]          w_lsat;
    logic [PW-1:0]           w_psat;
    logic                    w_wr_en;
    logic [AW-1:0]           w_wr_addr;
    logic                    w_rd_en;
    logic [AW-1:0]           w_rd_addr;
    logic [COEF_W-1:0]       w_rd_data;
    logic                    w_div_start;
    logic [LCW-1:0]          w_div_d;
    logic                    w_div_done;
    logic [Q30_W-1:0]        w_div_quot;
    logic [LCW-1:0]          w_div_rem;
    logic signed [Q30_W-1:0] w_ma, w_mb;
    logic signed [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0]       w_rnd30, w_rnd29;
    logic signed [SUM_W-1:0] w_term;
    logic signed [34:0]      w_diff;
    logic signed [Q30_W-1:0] w_tnext;
    logic signed [Q30_W-1:0] w_xnew;
    logic [JW-1:0]           w_j0, w_jn;
    logic [SUM_W-1:0]        w_mag;
    logic [THICK_W-1:0]      w_thick;
    logic                    w_last;
    logic [LCW:0]            w_rsum;
    logic [LCW:0]            w_dl;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);

    always_comb begin
        w_lsat = (32'(i_cmd.layer_count) > MAX_LAYERS) ? LCW'(MAX_LAYERS)
                                                       : LCW'(i_cmd.layer_count);
        w_psat = (32'(i_cmd.coef_count) > MAX_COEFS) ? PW'(MAX_COEFS)
                                                     : PW'(i_cmd.coef_count);
        w_wr_en   = w_accept && (i_cmd.op == OP_WRITE)
                    && (32'(i_cmd.coef_index) < MAX_COEFS);
        w_wr_addr = AW'(i_cmd.coef_index);
        w_div_d   = w_lsat - 1'b1;
    end

    csl_coef_ram #(
        .DEPTH  (MAX_COEFS),
        .DATA_W (COEF_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_cmd.coef_value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    csl_div #(
        .DIV_W (LCW),
        .Q_W   (Q30_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_divisor (w_div_d),
        .o_done    (w_div_done),
        .o_quot    (w_div_quot),
        .o_rem     (w_div_rem)
    );

    always_comb begin
        w_ma   = (r_state == S_MUL_C) ? $signed(w_rd_data) : r_x;
        w_mb   = (r_state == S_MUL_C) ? r_tprev : r_tcur;
        w_prod = w_ma * w_mb;

        w_rnd30 = r_prod + 64'sd536870912;
        w_term  = {{(SUM_W-34){w_rnd30[63]}}, w_rnd30[63:30]};

        w_rnd29 = r_prod + 64'sd268435456;
        w_diff  = $signed(w_rnd29[63:29]) - $signed({{3{r_tprev[31]}}, r_tprev});
        if (w_diff > 35'sd1073741824) begin
            w_tnext = $signed(ONE_Q30);
        end else if (w_diff < -35'sd1073741824) begin
            w_tnext = -$signed(ONE_Q30);
        end else begin
            w_tnext = w_diff[31:0];
        end

        w_xnew = $signed(r_xq - ONE_Q30);
        w_j0   = JW'(r_layer[0]);
        w_jn   = r_j + JW'(2);

        w_mag   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        w_thick = (w_mag[SUM_W-1:THICK_W] != '0) ? '1 : w_mag[THICK_W-1:0];
        w_last  = ((LCW'(r_layer) + 1'b1) == r_lcnt);

        w_dl   = (LCW+1)'(r_lcnt - 1'b1);
        w_rsum = (LCW+1)'(r_racc) + (LCW+1)'(r_ra);
    end

    always_comb begin
        n_state  = r_state;
        n_lcnt   = r_lcnt;
        n_pcnt   = r_pcnt;
        n_layer  = r_layer;
        n_xq     = r_xq;
        n_qa     = r_qa;
        n_ra     = r_ra;
        n_racc   = r_racc;
        n_j      = r_j;
        n_x      = r_x;
        n_tprev  = r_tprev;
        n_tcur   = r_tcur;
        n_sum    = r_sum;
        n_prod   = r_prod;
        n_strobe = 1'b0;
        n_result = r_result;
        w_rd_en     = 1'b0;
        w_rd_addr   = '0;
        w_div_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_cmd.op == OP_COMPUTE) && (w_lsat != '0)) begin
                    n_lcnt  = w_lsat;
                    n_pcnt  = w_psat;
                    n_layer = '0;
                    n_xq    = '0;
                    n_racc  = '0;
                    if (w_lsat == LCW'(1)) begin
                        n_state = S_LAYER;
                    end else begin
                        w_div_start = 1'b1;
                        n_state     = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_qa    = w_div_quot;
                    n_ra    = w_div_rem;
                    n_state = S_LAYER;
                end
            end
            S_LAYER: begin
                n_x     = w_xnew;
                n_tprev = $signed(ONE_Q30);
                n_tcur  = w_xnew;
                n_j     = w_j0;
                n_sum   = '0;
                if (w_j0 < JW'(r_pcnt)) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = AW'(w_j0);
                    n_state   = S_MUL_C;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_MUL_C: begin
                n_prod  = w_prod;
                n_state = S_MUL_X;
            end
            S_MUL_X: begin
                n_prod  = w_prod;
                n_sum   = r_sum + w_term;
                n_state = S_STEP;
            end
            S_STEP: begin
                n_tprev = r_tcur;
                n_tcur  = w_tnext;
                n_j     = w_jn;
                if (w_jn < JW'(r_pcnt)) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = AW'(w_jn);
                    n_state   = S_MUL_C;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_strobe             = 1'b1;
                n_result.layer_index = LAYER_IDX_W'(r_layer);
                n_result.thickness   = w_thick;
                n_result.last        = w_last;
                if (w_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_layer = r_layer + 1'b1;
                    if (w_rsum >= w_dl) begin
                        n_racc = LCW'(w_rsum - w_dl);
                        n_xq   = r_xq + r_qa + 1'b1;
                    end else begin
                        n_racc = LCW'(w_rsum);
                        n_xq   = r_xq + r_qa;
                    end
                    n_state = S_LAYER;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lcnt   <= n_lcnt;
        r_pcnt   <= n_pcnt;
        r_layer  <= n_layer;
        r_xq     <= n_xq;
        r_qa     <= n_qa;
        r_ra     <= n_ra;
        r_racc   <= n_racc;
        r_j      <= n_j;
        r_x      <= n_x;
        r_tprev  <= n_tprev;
        r_tcur   <= n_tcur;
        r_sum    <= n_sum;
        r_prod   <= n_prod;
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_zero_layers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd.op == OP_COMPUTE) && (i_cmd.layer_count == '0)) |=> !busy)
        else $error("empty compute transfer left the block busy");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |-> !busy)
        else $error("sequencer still running after final layer");

    a_step_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> ($past(r_state) == S_MUL_X))
        else $error("recurrence step without preceding multiply");

endmodule

// ----- design/csl_coef_ram.sv -----
// Coefficient store: synchronous single-write, single-read memory.
// Registered read data; entries never written since reset read as zero.
// No dependencies.
module csl_coef_ram #(
    parameter int DEPTH = 16,
    parameter int DATA_W = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [DATA_W-1:0]          i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [DATA_W-1:0]          o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/csl_div.sv -----
// Restoring bit-serial divider: (2^(Q_W-1)) / divisor, one quotient bit per cycle.
// Returns quotient and remainder with a one-cycle done pulse. No dependencies.
module csl_div #(
    parameter int DIV_W = 7,
    parameter int Q_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quot,
    output logic [DIV_W-1:0] o_rem
);

    localparam int CW = $clog2(Q_W);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DIV_W-1:0] r_d;
    logic [DIV_W-1:0] r_rem;
    logic [Q_W-1:0]   r_quot;

    logic             w_bit;
    logic [DIV_W:0]   w_rem2;
    logic [DIV_W:0]   w_sub;
    logic             w_ge;

    always_comb begin
        w_bit  = (r_cnt == CW'(Q_W - 1));
        w_rem2 = {r_rem, w_bit};
        w_ge   = (w_rem2 >= {1'b0, r_d});
        w_sub  = w_rem2 - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(Q_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d    <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_sub[DIV_W-1:0] : w_rem2[DIV_W-1:0];
            r_quot <= {r_quot[Q_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider restarted while running");

endmodule
